// ===== rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// shared constants, controller states and control/status bundles of the
// rgb box downscaler
// ----------------------------------------------------------------------------
package rbd_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;
	localparam int DIM_W       = 12;   // size and span edge width
	localparam int POS_W       = 11;   // pixel position width
	localparam int FRAC_W      = 11;   // edge remainder width
	localparam int ACC_W       = 30;   // channel sum width
	localparam int CNT_W       = 23;   // cell pixel count width
	localparam int CH_W        = 8;    // channel width
	localparam int NUM_CH      = 3;
	localparam int DIV_STEPS   = 30;   // one quotient bit per cycle
	localparam int DIV_CNT_W   = 5;
	localparam int SDIV_STEPS  = 12;
	localparam int SDIV_CNT_W  = 4;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 56;

	localparam logic [CH_W-1:0] OPAQUE_BYTE = 8'hFF;

	localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
	localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

	typedef enum logic [2:0] {
		ST_SETUP_GO,
		ST_SETUP_WAIT,
		ST_IDLE,
		ST_ACC,
		ST_DIV,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic cfg_we;
		logic setup_start;
		logic restart;
		logic pix_take;
		logic acc_en;
		logic div_start;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic setup_busy;
		logic cell_done;
		logic div_busy;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/rbd_acc_div.sv =====
// ----------------------------------------------------------------------------
// rbd_acc_div
// three-lane restoring divider, one quotient bit per cycle, shared divisor
// ----------------------------------------------------------------------------
module rbd_acc_div (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          start,
	input  logic [rbd_pkg::NUM_CH*rbd_pkg::ACC_W-1:0]     dividend,
	input  logic [rbd_pkg::CNT_W-1:0]                     divisor,
	output logic                                          busy,
	output logic [rbd_pkg::NUM_CH*rbd_pkg::CH_W-1:0]      quot_lo
);

	logic [rbd_pkg::ACC_W-1:0]     quo_q [rbd_pkg::NUM_CH];
	logic [rbd_pkg::CNT_W-1:0]     rem_q [rbd_pkg::NUM_CH];
	logic [rbd_pkg::ACC_W-1:0]     quo_d [rbd_pkg::NUM_CH];
	logic [rbd_pkg::CNT_W-1:0]     rem_d [rbd_pkg::NUM_CH];
	logic [rbd_pkg::CNT_W-1:0]     div_q;
	logic [rbd_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;

	// one restoring step per lane
	always_comb begin
		logic [rbd_pkg::CNT_W:0] t;
		for (int i = 0; i < rbd_pkg::NUM_CH; i++) begin
			t = {rem_q[i], quo_q[i][rbd_pkg::ACC_W-1]};
			if (t >= {1'b0, div_q}) begin
				rem_d[i] = rbd_pkg::CNT_W'(t - {1'b0, div_q});
				quo_d[i] = {quo_q[i][rbd_pkg::ACC_W-2:0], 1'b1};
			end else begin
				rem_d[i] = t[rbd_pkg::CNT_W-1:0];
				quo_d[i] = {quo_q[i][rbd_pkg::ACC_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= rbd_pkg::DIV_CNT_W'(rbd_pkg::DIV_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			for (int i = 0; i < rbd_pkg::NUM_CH; i++) begin
				quo_q[i] <= dividend[i*rbd_pkg::ACC_W +: rbd_pkg::ACC_W];
				rem_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < rbd_pkg::NUM_CH; i++) begin
				quo_q[i] <= quo_d[i];
				rem_q[i] <= rem_d[i];
			end
		end
	end

	assign busy = busy_q;

	always_comb begin
		for (int i = 0; i < rbd_pkg::NUM_CH; i++) begin
			quot_lo[i*rbd_pkg::CH_W +: rbd_pkg::CH_W] = quo_q[i][rbd_pkg::CH_W-1:0];
		end
	end

endmodule

// ===== rtl/rbd_dp.sv =====
// ----------------------------------------------------------------------------
// rbd_dp
// datapath: config registers, span edge tracking, column accumulators,
// cell divider and output register
// ----------------------------------------------------------------------------
module rbd_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rbd_pkg::cmd_t                      cmd,
	output rbd_pkg::sts_t                      sts,
	input  logic [1:0]                         cfg_index,
	input  logic [rbd_pkg::DIM_W-1:0]          cfg_data,
	input  logic [rbd_pkg::IN_DATA_W-1:0]      pix_data,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [rbd_pkg::OUT_DATA_W-1:0]     out_data,
	output logic                               out_last
);

	localparam int DW  = rbd_pkg::DIM_W;
	localparam int PW  = rbd_pkg::POS_W;
	localparam int FW  = rbd_pkg::FRAC_W;
	localparam int AW  = rbd_pkg::ACC_W;
	localparam int CW  = rbd_pkg::CH_W;
	localparam int MW  = rbd_pkg::NUM_CH * AW;

	// setup division step: {rem, quo}
	function automatic logic [2*DW-1:0] sdiv_step(input logic [DW-1:0] rem,
			input logic [DW-1:0] quo, input logic [DW-1:0] d);
		logic [DW:0] t;
		t = {rem, quo[DW-1]};
		if (t >= {1'b0, d}) begin
			sdiv_step = {DW'(t - {1'b0, d}), quo[DW-2:0], 1'b1};
		end else begin
			sdiv_step = {t[DW-1:0], quo[DW-2:0], 1'b0};
		end
	endfunction

	// next span edge: {edge, frac}
	function automatic logic [DW+FW-1:0] edge_step(input logic [DW-1:0] e,
			input logic [FW-1:0] fr, input logic [DW-1:0] base,
			input logic [FW-1:0] rm, input logic [DW-1:0] d);
		logic [DW-1:0] s;
		s = {1'b0, fr} + {1'b0, rm};
		if (s >= d) begin
			edge_step = {DW'(e + base + 1'b1), FW'(s - d)};
		end else begin
			edge_step = {DW'(e + base), s[FW-1:0]};
		end
	endfunction

	logic [DW-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [DW-1:0] sw, sh, dw, dh;

	logic                        sd_busy_q;
	logic [rbd_pkg::SDIV_CNT_W-1:0] sd_cnt_q;
	logic [DW-1:0] base_c_q, rem_c_q, base_r_q, rem_r_q;

	logic [PW-1:0] src_col_q, src_row_q, dst_col_q, dst_row_q, col_start_q, band_top_q;
	logic [DW-1:0] col_edge_q, row_edge_q;
	logic [FW-1:0] col_frac_q, row_frac_q;

	logic [MW-1:0] acc_mem [rbd_pkg::MAX_WIDTH];
	logic [MW-1:0] rd_q;
	logic [rbd_pkg::IN_DATA_W-1:0] pix_q;
	logic [CW-1:0] pix_c [rbd_pkg::NUM_CH];

	logic [MW-1:0] sum_new;
	logic          first_px, col_end, row_end, col_last, row_last;
	logic [DW-1:0] cw, ch;
	logic [2*DW-1:0] cnt_prod;
	logic [DW+FW-1:0] col_nx, row_nx;

	logic [PW-1:0] cell_col_q, cell_row_q;
	logic          cell_last_q;
	logic          div_busy;
	logic [rbd_pkg::NUM_CH*CW-1:0] quot_lo;

	logic          out_valid_q, out_last_q;
	logic [rbd_pkg::OUT_DATA_W-1:0] out_data_q;

	// effective sizes after clamping
	always_comb begin
		sw = src_w_q;
		if (src_w_q == '0) sw = DW'(1);
		else if (src_w_q > DW'(rbd_pkg::MAX_WIDTH)) sw = DW'(rbd_pkg::MAX_WIDTH);
		sh = src_h_q;
		if (src_h_q == '0) sh = DW'(1);
		else if (src_h_q > DW'(rbd_pkg::MAX_HEIGHT)) sh = DW'(rbd_pkg::MAX_HEIGHT);
		dw = dst_w_q;
		if (dst_w_q == '0) dw = DW'(1);
		else if (dst_w_q > sw) dw = sw;
		dh = dst_h_q;
		if (dst_h_q == '0) dh = DW'(1);
		else if (dst_h_q > sh) dh = sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= DW'(1);
			src_h_q <= DW'(1);
			dst_w_q <= DW'(1);
			dst_h_q <= DW'(1);
		end else if (cmd.cfg_we) begin
			case (cfg_index)
				rbd_pkg::REG_SRC_WIDTH:  src_w_q <= cfg_data;
				rbd_pkg::REG_SRC_HEIGHT: src_h_q <= cfg_data;
				rbd_pkg::REG_DST_WIDTH:  dst_w_q <= cfg_data;
				rbd_pkg::REG_DST_HEIGHT: dst_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// edge step size src/dst per axis, quotient and remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_busy_q <= 1'b0;
			sd_cnt_q  <= '0;
			base_c_q  <= '0;
			rem_c_q   <= '0;
			base_r_q  <= '0;
			rem_r_q   <= '0;
		end else if (cmd.setup_start) begin
			sd_busy_q <= 1'b1;
			sd_cnt_q  <= rbd_pkg::SDIV_CNT_W'(rbd_pkg::SDIV_STEPS - 1);
			base_c_q  <= sw;
			rem_c_q   <= '0;
			base_r_q  <= sh;
			rem_r_q   <= '0;
		end else if (sd_busy_q) begin
			{rem_c_q, base_c_q} <= sdiv_step(rem_c_q, base_c_q, dw);
			{rem_r_q, base_r_q} <= sdiv_step(rem_r_q, base_r_q, dh);
			if (sd_cnt_q == '0) sd_busy_q <= 1'b0;
			sd_cnt_q <= sd_cnt_q - 1'b1;
		end
	end

	// per pixel decisions
	always_comb begin
		first_px = (src_row_q == band_top_q) && (src_col_q == col_start_q);
		col_end  = ({1'b0, src_col_q} + 1'b1) >= col_edge_q;
		row_end  = ({1'b0, src_row_q} + 1'b1) >= row_edge_q;
		col_last = ({1'b0, src_col_q} + 1'b1) >= sw;
		row_last = ({1'b0, src_row_q} + 1'b1) >= sh;
		cw = (col_edge_q > {1'b0, col_start_q}) ? DW'(col_edge_q - {1'b0, col_start_q}) : DW'(1);
		ch = (row_edge_q > {1'b0, band_top_q}) ? DW'(row_edge_q - {1'b0, band_top_q}) : DW'(1);
		cnt_prod = cw * ch;
		col_nx = edge_step(col_edge_q, col_frac_q, base_c_q, rem_c_q[FW-1:0], dw);
		row_nx = edge_step(row_edge_q, row_frac_q, base_r_q, rem_r_q[FW-1:0], dh);
		for (int i = 0; i < rbd_pkg::NUM_CH; i++) begin
			pix_c[i] = pix_q[i*CW +: CW];
			if (first_px) begin
				sum_new[i*AW +: AW] = AW'(pix_c[i]);
			end else begin
				sum_new[i*AW +: AW] = AW'(rd_q[i*AW +: AW] + AW'(pix_c[i]));
			end
		end
	end

	// position and span edge tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q   <= '0;
			src_row_q   <= '0;
			dst_col_q   <= '0;
			dst_row_q   <= '0;
			col_start_q <= '0;
			band_top_q  <= '0;
			col_edge_q  <= '0;
			row_edge_q  <= '0;
			col_frac_q  <= '0;
			row_frac_q  <= '0;
		end else if (cmd.restart || (cmd.acc_en && col_last && row_last)) begin
			src_col_q   <= '0;
			src_row_q   <= '0;
			dst_col_q   <= '0;
			dst_row_q   <= '0;
			col_start_q <= '0;
			band_top_q  <= '0;
			col_edge_q  <= base_c_q;
			row_edge_q  <= base_r_q;
			col_frac_q  <= rem_c_q[FW-1:0];
			row_frac_q  <= rem_r_q[FW-1:0];
		end else if (cmd.acc_en) begin
			if (col_last) begin
				src_col_q   <= '0;
				dst_col_q   <= '0;
				col_start_q <= '0;
				col_edge_q  <= base_c_q;
				col_frac_q  <= rem_c_q[FW-1:0];
				src_row_q   <= src_row_q + 1'b1;
				if (row_end) begin
					band_top_q <= row_edge_q[PW-1:0];
					dst_row_q  <= dst_row_q + 1'b1;
					{row_edge_q, row_frac_q} <= row_nx;
				end
			end else begin
				src_col_q <= src_col_q + 1'b1;
				if (col_end) begin
					col_start_q <= col_edge_q[PW-1:0];
					dst_col_q   <= dst_col_q + 1'b1;
					{col_edge_q, col_frac_q} <= col_nx;
				end
			end
		end
	end

	// column accumulators, pixel held from accept to read-modify-write
	always_ff @(posedge clk) begin
		if (cmd.pix_take) begin
			rd_q  <= acc_mem[dst_col_q];
			pix_q <= pix_data;
		end
		if (cmd.acc_en) begin
			acc_mem[dst_col_q] <= sum_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			cell_col_q  <= dst_col_q;
			cell_row_q  <= dst_row_q;
			cell_last_q <= (({1'b0, dst_col_q} + 1'b1) >= dw) &&
				(({1'b0, dst_row_q} + 1'b1) >= dh);
		end
	end

	rbd_acc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_new),
		.divisor  (cnt_prod[rbd_pkg::CNT_W-1:0]),
		.busy     (div_busy),
		.quot_lo  (quot_lo)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_data_q <= {2'b00, cell_row_q, cell_col_q, rbd_pkg::OPAQUE_BYTE, quot_lo};
			out_last_q <= cell_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	always_comb begin
		sts.setup_busy = sd_busy_q;
		sts.cell_done  = col_end && row_end;
		sts.div_busy   = div_busy;
		sts.out_free   = !out_valid_q || out_ready;
	end

endmodule

// ===== rtl/rbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbd_ctrl
// controller: setup division, pixel accept, accumulate, cell divide, push
// ----------------------------------------------------------------------------
module rbd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          pix_valid,
	output logic          pix_ready,
	input  rbd_pkg::sts_t sts,
	output rbd_pkg::cmd_t cmd
);

	rbd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbd_pkg::ST_SETUP_GO;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cfg_ready = 1'b0;
		pix_ready = 1'b0;
		case (state_q)
			rbd_pkg::ST_SETUP_GO: begin
				cmd.setup_start = 1'b1;
				state_d = rbd_pkg::ST_SETUP_WAIT;
			end
			rbd_pkg::ST_SETUP_WAIT: begin
				if (!sts.setup_busy) begin
					cmd.restart = 1'b1;
					state_d = rbd_pkg::ST_IDLE;
				end
			end
			rbd_pkg::ST_IDLE: begin
				cfg_ready = 1'b1;
				pix_ready = !cfg_valid;
				if (cfg_valid) begin
					cmd.cfg_we = 1'b1;
					state_d = rbd_pkg::ST_SETUP_GO;
				end else if (pix_valid) begin
					cmd.pix_take = 1'b1;
					state_d = rbd_pkg::ST_ACC;
				end
			end
			rbd_pkg::ST_ACC: begin
				cmd.acc_en = 1'b1;
				if (sts.cell_done) begin
					cmd.div_start = 1'b1;
					state_d = rbd_pkg::ST_DIV;
				end else begin
					state_d = rbd_pkg::ST_IDLE;
				end
			end
			rbd_pkg::ST_DIV: begin
				if (!sts.div_busy) state_d = rbd_pkg::ST_PUSH;
			end
			rbd_pkg::ST_PUSH: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d = rbd_pkg::ST_IDLE;
				end
			end
			default: state_d = rbd_pkg::ST_SETUP_GO;
		endcase
	end

endmodule

// ===== rtl/rgb_box_downscale_top.sv =====
// ----------------------------------------------------------------------------
// rgb_box_downscale_top
// area-average (box filter) rgb downscaler for raster-order pixel streams
// ----------------------------------------------------------------------------
// Source pixels come in one item each on the s_axis side in raster order; the
// block sums bytes 0..2 per destination column and, on the last source pixel of
// a destination cell, sends one item with the truncated channel means (byte 3
// forced to 0xff) and the cell's column and row; tlast marks the frame's last
// cell. Spans on each axis are floor(i*src/dst) with dst clamped to 1..src.
// A pixel that closes no cell is accepted, then added to its accumulator by a
// read-modify-write; a pixel that closes a cell goes through accept,
// read-modify-write, the 30-step serial divider that turns the three sums
// into means, and the push into the output register (which waits while that
// register is still full). tready stays low until the pixel is through.
// After reset and after every config write the block computes the per-axis
// edge step with a 12-step serial divider, and restarts the frame at pixel
// (0,0); tready is low during that time. Config writes
// (index 0 src width, 1 src height, 2 dst width, 3 dst height) belong between
// frames with no result pending.
module rgb_box_downscale_top (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	// source pixels
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] src_pixel
	// averaged pixels
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [31:0] out_pixel, [42:32] out_col, [53:43] out_row
	output logic        m_axis_tlast    // frame_end
);

	rbd_pkg::cmd_t cmd;
	rbd_pkg::sts_t sts;

	// sequencing of setup, accumulate, divide and push
	rbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.pix_valid (s_axis_tvalid),
		.pix_ready (s_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// registers, accumulators, dividers and output register
	rbd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_data  (s_axis_tdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ===== bench/tb_rgb_box_downscale_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_box_downscale_top
// self-checking bench for the box filter downscaler: a software downscaler
// predicts every averaged pixel from the accepted source pixels, and the
// received items are compared field by field in order, over several frame
// sizes and idle patterns
// ----------------------------------------------------------------------------

typedef struct {
	logic [31:0] pix;
	logic [10:0] col;
	logic [10:0] row;
	logic        last;
} cell_t;

class cell_scoreboard;
	int unsigned sw, sh, dw, dh;
	logic [11:0] r_sw, r_sh, r_dw, r_dh;
	logic [29:0] sum0 [rbd_pkg::MAX_WIDTH];
	logic [29:0] sum1 [rbd_pkg::MAX_WIDTH];
	logic [29:0] sum2 [rbd_pkg::MAX_WIDTH];
	int unsigned scol, srow, dcol, drow, col_edge, row_edge, band_top, col_start;
	cell_t pending [$];
	int errors;

	function new();
		r_sw = 1; r_sh = 1; r_dw = 1; r_dh = 1;
		errors = 0;
		restart();
	endfunction

	function int unsigned edge_at(int unsigned i, int unsigned s, int unsigned d);
		return (i * s) / d;
	endfunction

	function void restart();
		sw = (r_sw == 0) ? 1 : (r_sw > rbd_pkg::MAX_WIDTH ? rbd_pkg::MAX_WIDTH : r_sw);
		sh = (r_sh == 0) ? 1 : (r_sh > rbd_pkg::MAX_HEIGHT ? rbd_pkg::MAX_HEIGHT : r_sh);
		dw = (r_dw == 0) ? 1 : (r_dw > sw ? sw : r_dw);
		dh = (r_dh == 0) ? 1 : (r_dh > sh ? sh : r_dh);
		scol = 0; srow = 0; dcol = 0; drow = 0; band_top = 0; col_start = 0;
		col_edge = edge_at(1, sw, dw);
		row_edge = edge_at(1, sh, dh);
	endfunction

	function void write_reg(logic [1:0] idx, logic [11:0] v);
		case (idx)
			rbd_pkg::REG_SRC_WIDTH:  r_sw = v;
			rbd_pkg::REG_SRC_HEIGHT: r_sh = v;
			rbd_pkg::REG_DST_WIDTH:  r_dw = v;
			rbd_pkg::REG_DST_HEIGHT: r_dh = v;
			default: ;
		endcase
		restart();
	endfunction

	// note an accepted source pixel
	function void note_pixel(logic [31:0] px);
		bit cend, rend;
		int unsigned cnt;
		cell_t c;
		if (srow == band_top && scol == col_start) begin
			sum0[dcol] = px[7:0]; sum1[dcol] = px[15:8]; sum2[dcol] = px[23:16];
		end else begin
			sum0[dcol] += px[7:0]; sum1[dcol] += px[15:8]; sum2[dcol] += px[23:16];
		end
		cend = scol + 1 >= col_edge;
		rend = srow + 1 >= row_edge;
		if (cend && rend) begin
			cnt = (col_edge - col_start) * (row_edge - band_top);
			c.pix = {rbd_pkg::OPAQUE_BYTE, 8'(sum2[dcol] / cnt), 8'(sum1[dcol] / cnt),
				8'(sum0[dcol] / cnt)};
			c.col = 11'(dcol);
			c.row = 11'(drow);
			c.last = (dcol + 1 >= dw) && (drow + 1 >= dh);
			pending.push_back(c);
		end
		if (cend) begin
			col_start = col_edge;
			dcol++;
			col_edge = edge_at(dcol + 1, sw, dw);
		end
		scol++;
		if (scol >= sw) begin
			scol = 0; dcol = 0; col_start = 0;
			col_edge = edge_at(1, sw, dw);
			if (rend) begin
				band_top = row_edge;
				drow++;
				row_edge = edge_at(drow + 1, sh, dh);
			end
			srow++;
			if (srow >= sh) restart();
		end
	endfunction

	task report(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	task check_cell(logic [55:0] d, logic last);
		cell_t c;
		if (pending.size() == 0) begin
			report("unexpected item", d, 0);
			return;
		end
		c = pending.pop_front();
		if (d[31:0] !== c.pix) report("out_pixel", d[31:0], c.pix);
		if (d[42:32] !== c.col) report("out_col", d[42:32], c.col);
		if (d[53:43] !== c.row) report("out_row", d[53:43], c.row);
		if (last !== c.last) report("frame_end", last, c.last);
	endtask
endclass

module tb_rgb_box_downscale_top;
	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [11:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tlast;

	cell_scoreboard sb;
	int src_idle_pct;   // chance per cycle that the sender holds back
	int snk_idle_pct;   // chance per cycle that the receiver stalls
	int hold_cycles;    // long receiver hold-off, counted by the sink
	longint cycles;

	rgb_box_downscale_top uut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// run limit: cell items, stalls and setup passes, times margin
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("rgb_box_downscale_top verification failed");
			$finish;
		end
	end

	// result side: sample at rising edge, change ready at falling edge
	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_cell(m_axis_tdata, m_axis_tlast);

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic write_cfg(logic [1:0] idx, logic [11:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until all predicted cells are out, then let a cell in flight finish
	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_size(int w, int h, int dwid, int dhei);
		drain();
		write_cfg(rbd_pkg::REG_SRC_WIDTH, 12'(w));
		write_cfg(rbd_pkg::REG_SRC_HEIGHT, 12'(h));
		write_cfg(rbd_pkg::REG_DST_WIDTH, 12'(dwid));
		write_cfg(rbd_pkg::REG_DST_HEIGHT, 12'(dhei));
	endtask

	task automatic send_pixel(logic [31:0] px);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_pixel(px);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic send_frame(int n, bit extremes);
		logic [31:0] px;
		for (int i = 0; i < n; i++) begin
			px = $urandom();
			if (extremes) px = (i % 2) ? 32'hFFFF_FFFF : 32'h0;
			send_pixel(px);
		end
	endtask

	initial begin
		int w, h;
		sb = new();
		cycles = 0;
		hold_cycles = 0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = rbd_pkg::REG_SRC_WIDTH;
		cfg_data = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		m_axis_tready = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset size 1x1, then extremes of channel values
		send_frame(2, 1);
		set_size(4, 2, 2, 1);
		send_frame(8, 1);
		// zero sizes clamp to one, oversized destination clamps to source
		set_size(3, 0, 9, 0);
		send_frame(3, 0);
		set_size(3, 3, 2, 2);
		send_frame(9, 0);
		// index beyond the list is not reachable on a 2-bit index

		// random part across three idle phases
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 62 : 0;
			snk_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 24 : 0;
			for (int f = 0; f < 8; f++) begin
				w = $urandom_range(1, 16);
				h = $urandom_range(1, 10);
				// frame large enough to fill the block during the hold-off
				if (f == 2) begin w = 12; h = 4; end
				set_size(w, h, $urandom_range(0, 18), $urandom_range(0, 11));
				if (f == 2) hold_cycles = 300;
				send_frame(w * h, 0);
			end
			// sender pauses until every result is in
			while (sb.pending.size() != 0) @(posedge clk);
		end
		// top codes of every register
		set_size(4095, 4095, 4095, 4095);
		send_frame(20, 0);
		set_size(2048, 2, 2048, 2048);
		send_frame(30, 0);

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("rgb_box_downscale_top verification clean");
		else
			$display("rgb_box_downscale_top verification failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/rbd_pkg.sv
rtl/rbd_acc_div.sv
rtl/rbd_dp.sv
rtl/rbd_ctrl.sv
rtl/rgb_box_downscale_top.sv
bench/tb_rgb_box_downscale_top.sv
